@@ hw/rtl/dps_pkg.sv @@
// Shared types and constants for the dynamic priority scheduler.
`default_nettype none
package dps_pkg;

	localparam int PRI_W = 13;
	localparam int CFG_W = 8;

	typedef logic signed [PRI_W-1:0] pri_t;

	typedef struct packed {
		logic       valid;
		logic       done;
		logic [7:0] rem;
		pri_t       pri;
		logic [7:0] cpu;
	} slot_t;

	localparam logic       OP_ADD  = 1'b0;
	localparam logic       OP_TICK = 1'b1;

	localparam logic [1:0] ST_ADDED  = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_RAN    = 2'd2;
	localparam logic [1:0] ST_IDLE   = 2'd3;

	localparam logic       REG_BASE = 1'b0;
	localparam logic       REG_STEP = 1'b1;

	localparam logic [7:0] BASE_RST = 8'd50;
	localparam logic [3:0] STEP_RST = 4'd3;

	localparam pri_t       PRI_MIN  = -13'sd4096;
	localparam logic [7:0] CPU_MAX  = 8'd255;

endpackage
`default_nettype wire

@@ hw/rtl/dynamic_priority_scheduler_top.sv @@
// Top level: process table as a ring of slot cells plus the scan sequencer.
// An add or a tick first takes one pass over the ring to pick the slot and, if one is
// picked, a second pass to update it; a rejected add or an idle tick ends after the
// first pass. One comparator at the ring head sees one slot per cycle. A new request
// is taken in the cycle done is high. Results cannot be stalled. Reset empties the
// table and loads 50 and 3.
`default_nettype none
module dynamic_priority_scheduler_top #(
	parameter int SLOTS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      op,
	input  wire logic [7:0]                need_time,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_addr,
	input  wire logic [dps_pkg::CFG_W-1:0] cfg_wdata,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [3:0]                     slot_id,
	output logic [7:0]                     remaining_time,
	output logic signed [12:0]             priority_now,
	output logic [7:0]                     cpu_used,
	output logic                           finished
);

	logic [7:0] base_q;
	logic [3:0] step_q;

	dps_pkg::slot_t ring [SLOTS];
	dps_pkg::slot_t wb;
	logic           shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= dps_pkg::BASE_RST;
			step_q <= dps_pkg::STEP_RST;
		end else if (cfg_we) begin
			if (cfg_addr == dps_pkg::REG_BASE)
				base_q <= cfg_wdata;
			if (cfg_addr == dps_pkg::REG_STEP)
				step_q <= cfg_wdata[3:0];
		end
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		dps_pkg::slot_t d;
		if (i == SLOTS - 1) begin : g_tail
			assign d = wb;
		end else begin : g_mid
			assign d = ring[i+1];
		end
		dps_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (ring[i])
		);
	end

	dps_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.op             (op),
		.need_time      (need_time),
		.base           (base_q),
		.step           (step_q),
		.head           (ring[0]),
		.wb             (wb),
		.shift          (shift),
		.busy           (busy),
		.done           (done),
		.status         (status),
		.slot_id        (slot_id),
		.remaining_time (remaining_time),
		.priority_now   (priority_now),
		.cpu_used       (cpu_used),
		.finished       (finished)
	);

endmodule
`default_nettype wire

@@ hw/rtl/dps_cell.sv @@
// One slot of the rotating process table.
`default_nettype none
module dps_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           shift,
	input  wire dps_pkg::slot_t d,
	output dps_pkg::slot_t      q
);

	logic       valid_q;
	logic       done_q;
	logic [7:0] rem_q;
	dps_pkg::pri_t pri_q;
	logic [7:0] cpu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
			done_q  <= d.done;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			rem_q <= d.rem;
			pri_q <= d.pri;
			cpu_q <= d.cpu;
		end
	end

	assign q = '{valid: valid_q, done: done_q, rem: rem_q, pri: pri_q, cpu: cpu_q};

endmodule
`default_nettype wire

@@ hw/rtl/dps_ctrl.sv @@
// Sequencer: scans the ring head for a target slot, then, unless it rejects, updates it on the next pass.
`default_nettype none
module dps_ctrl #(
	parameter int SLOTS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           op,
	input  wire logic [7:0]     need_time,
	input  wire logic [7:0]     base,
	input  wire logic [3:0]     step,
	input  wire dps_pkg::slot_t head,
	output dps_pkg::slot_t      wb,
	output logic                shift,
	output logic                busy,
	output logic                done,
	output logic [1:0]          status,
	output logic [3:0]          slot_id,
	output logic [7:0]          remaining_time,
	output logic signed [12:0]  priority_now,
	output logic [7:0]          cpu_used,
	output logic                finished
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] cnt_q;
	logic          found_q;
	logic          done_q;
	logic          op_q;
	logic [7:0]    need_q;
	logic [IW-1:0] tgt_q;
	dps_pkg::pri_t best_pri_q;

	logic [1:0]         status_q;
	logic [3:0]         slot_id_q;
	logic [7:0]         rem_out_q;
	dps_pkg::pri_t      pri_out_q;
	logic [7:0]         cpu_out_q;
	logic               fin_q;

	logic          free;
	logic          ready;
	logic          take;
	logic          found_n;
	logic          last;
	logic          apply_hit;
	logic          reject;
	logic [7:0]    rem_dec;
	logic signed [13:0] pri_dec;
	dps_pkg::pri_t pri_sat;
	dps_pkg::pri_t pri_add;
	logic [IW+3:0] tgt_ext;

	always_comb begin
		free      = !head.valid || head.done;
		ready     = head.valid && !head.done;
		take      = 1'b0;
		if (state_q == S_SCAN) begin
			if (op_q == dps_pkg::OP_ADD)
				take = !found_q && free;
			else
				take = ready && (!found_q || ($signed(head.pri) > best_pri_q));
		end
		found_n   = found_q || take;
		last      = (cnt_q == IW'(SLOTS - 1));
		apply_hit = (state_q == S_APPLY) && (cnt_q == tgt_q);
		reject    = (op_q == dps_pkg::OP_ADD) ? (!found_n || need_q == 8'd0) : !found_n;

		rem_dec = (head.rem != 8'd0) ? head.rem - 8'd1 : 8'd0;
		pri_dec = {head.pri[12], head.pri} - $signed({10'd0, step});
		pri_sat = (pri_dec < -14'sd4096) ? dps_pkg::PRI_MIN : pri_dec[12:0];
		pri_add = $signed({5'd0, base}) - $signed({5'd0, need_q});

		wb = head;
		if (apply_hit) begin
			if (op_q == dps_pkg::OP_ADD) begin
				wb.valid = 1'b1;
				wb.done  = 1'b0;
				wb.rem   = need_q;
				wb.pri   = pri_add;
				wb.cpu   = 8'd0;
			end else begin
				wb.pri  = pri_sat;
				wb.cpu  = (head.cpu == dps_pkg::CPU_MAX) ? head.cpu : head.cpu + 8'd1;
				wb.rem  = rem_dec;
				wb.done = (rem_dec == 8'd0);
			end
		end
		tgt_ext = {4'd0, tgt_q};
	end

	assign shift = (state_q != S_IDLE);
	assign busy  = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					cnt_q   <= cnt_q + IW'(1);
					found_q <= found_n;
					if (last) begin
						cnt_q <= '0;
						if (reject) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_APPLY;
						end
					end
				end
				S_APPLY: begin
					cnt_q <= cnt_q + IW'(1);
					if (last) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q   <= op;
			need_q <= need_time;
		end
		if (take) begin
			tgt_q      <= cnt_q;
			best_pri_q <= head.pri;
		end
		if (state_q == S_SCAN && last && reject) begin
			status_q  <= (op_q == dps_pkg::OP_ADD) ? dps_pkg::ST_REJECT : dps_pkg::ST_IDLE;
			slot_id_q <= 4'd0;
			rem_out_q <= 8'd0;
			pri_out_q <= '0;
			cpu_out_q <= 8'd0;
			fin_q     <= 1'b0;
		end
		if (apply_hit) begin
			status_q  <= (op_q == dps_pkg::OP_ADD) ? dps_pkg::ST_ADDED : dps_pkg::ST_RAN;
			slot_id_q <= tgt_ext[3:0];
			rem_out_q <= wb.rem;
			pri_out_q <= wb.pri;
			cpu_out_q <= wb.cpu;
			fin_q     <= (op_q == dps_pkg::OP_TICK) && wb.done;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign slot_id        = slot_id_q;
	assign remaining_time = rem_out_q;
	assign priority_now   = pri_out_q;
	assign cpu_used       = cpu_out_q;
	assign finished       = fin_q;

endmodule
`default_nettype wire

@@ hw/rtl/dps_checker.sv @@
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none
module dps_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [1:0]        status,
	input wire logic [3:0]        slot_id,
	input wire logic [7:0]        remaining_time,
	input wire logic signed [12:0] priority_now,
	input wire logic [7:0]        cpu_used,
	input wire logic              finished
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == dps_pkg::ST_REJECT || status == dps_pkg::ST_IDLE) |->
		slot_id == 4'd0 && remaining_time == 8'd0 && priority_now == 13'sd0 &&
		cpu_used == 8'd0 && !finished)
		else $error("reject or idle result carries data");

	a_add_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == dps_pkg::ST_ADDED |->
		!finished && cpu_used == 8'd0 && remaining_time != 8'd0)
		else $error("bad add result");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done && finished |-> status == dps_pkg::ST_RAN && remaining_time == 8'd0)
		else $error("finished flag on a result that did not complete");

endmodule

bind dynamic_priority_scheduler_top dps_checker u_dps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.slot_id        (slot_id),
	.remaining_time (remaining_time),
	.priority_now   (priority_now),
	.cpu_used       (cpu_used),
	.finished       (finished)
);
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for dynamic_priority_scheduler_top: directed and random requests.
module testbench;

	localparam int NSLOTS = 16;
	localparam int SETTLE_CYCLES = 2 * NSLOTS + 4;

	typedef struct {
		logic [1:0]    status;
		logic [3:0]    slot;
		logic [7:0]    rem;
		dps_pkg::pri_t pri;
		logic [7:0]    cpu;
		logic          fin;
	} sched_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             op = dps_pkg::OP_ADD;
	logic [7:0]       need_time = 8'd0;
	logic             cfg_we = 1'b0;
	logic             cfg_addr = dps_pkg::REG_BASE;
	logic [dps_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic             busy;
	logic             done;
	logic [1:0]       status;
	logic [3:0]       slot_id;
	logic [7:0]       remaining_time;
	logic signed [12:0] priority_now;
	logic [7:0]       cpu_used;
	logic             finished;

	// process table as the scheduler should hold it
	logic          tbl_valid [NSLOTS];
	logic          tbl_done  [NSLOTS];
	logic [7:0]    tbl_rem   [NSLOTS];
	dps_pkg::pri_t tbl_pri   [NSLOTS];
	logic [7:0]    tbl_cpu   [NSLOTS];
	logic [7:0] cur_base = dps_pkg::BASE_RST;
	logic [3:0] cur_step = dps_pkg::STEP_RST;

	sched_result_t pending_results[$];
	int failures = 0;

	dynamic_priority_scheduler_top #(.SLOTS(NSLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.need_time(need_time), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .done(done), .status(status), .slot_id(slot_id),
		.remaining_time(remaining_time), .priority_now(priority_now),
		.cpu_used(cpu_used), .finished(finished)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NSLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_done[i] = 1'b0;
			tbl_rem[i] = '0;
			tbl_pri[i] = '0;
			tbl_cpu[i] = '0;
		end
	end

	function automatic sched_result_t schedule_step(input logic o, input logic [7:0] n);
		sched_result_t r;
		int pick;
		int p;
		r = '{status: dps_pkg::ST_REJECT, slot: '0, rem: '0, pri: '0, cpu: '0,
			fin: 1'b0};
		pick = -1;
		if (o == dps_pkg::OP_ADD) begin
			for (int i = 0; i < NSLOTS; i++)
				if (pick < 0 && (!tbl_valid[i] || tbl_done[i]))
					pick = i;
			if (pick >= 0 && n != 8'd0) begin
				tbl_valid[pick] = 1'b1;
				tbl_done[pick] = 1'b0;
				tbl_rem[pick] = n;
				tbl_pri[pick] = dps_pkg::pri_t'(int'(cur_base) - int'(n));
				tbl_cpu[pick] = '0;
				r.status = dps_pkg::ST_ADDED;
				r.slot = pick[3:0];
				r.rem = n;
				r.pri = tbl_pri[pick];
			end
		end else begin
			for (int i = 0; i < NSLOTS; i++)
				if (tbl_valid[i] && !tbl_done[i])
					if (pick < 0 || tbl_pri[i] > tbl_pri[pick])
						pick = i;
			if (pick < 0) begin
				r.status = dps_pkg::ST_IDLE;
			end else begin
				p = int'(tbl_pri[pick]) - int'(cur_step);
				if (p < int'(dps_pkg::PRI_MIN))
					p = int'(dps_pkg::PRI_MIN);
				tbl_pri[pick] = dps_pkg::pri_t'(p);
				if (tbl_cpu[pick] != dps_pkg::CPU_MAX)
					tbl_cpu[pick] = tbl_cpu[pick] + 8'd1;
				if (tbl_rem[pick] != 8'd0)
					tbl_rem[pick] = tbl_rem[pick] - 8'd1;
				if (tbl_rem[pick] == 8'd0) begin
					tbl_done[pick] = 1'b1;
					r.fin = 1'b1;
				end
				r.status = dps_pkg::ST_RAN;
				r.slot = pick[3:0];
				r.rem = tbl_rem[pick];
				r.pri = tbl_pri[pick];
				r.cpu = tbl_cpu[pick];
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [15:0] want,
			input logic signed [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : check_results
		sched_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unrequested result: status %0d slot %0d", status, slot_id);
				failures++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("slot_id", want.slot, slot_id);
				check_field("remaining_time", want.rem, remaining_time);
				check_field("priority_now", want.pri, priority_now);
				check_field("cpu_used", want.cpu, cpu_used);
				check_field("finished", want.fin, finished);
			end
		end
	end

	// leaves start high so a following request can go back to back
	task automatic issue_request(input logic o, input logic [7:0] n);
		start <= 1'b1;
		op <= o;
		need_time <= n;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(schedule_step(o, n));
	endtask

	task automatic sender_gap(input bit gaps_on);
		int roll;
		int g;
		roll = $urandom_range(0, 99);
		g = 0;
		if (gaps_on && roll >= 65)
			g = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] b, input logic [3:0] s);
		cfg_we <= 1'b1;
		cfg_addr <= dps_pkg::REG_BASE;
		cfg_wdata <= b;
		@(posedge clk);
		cur_base = b;
		cfg_addr <= dps_pkg::REG_STEP;
		cfg_wdata <= {4'd0, s};
		@(posedge clk);
		cur_step = s;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_need();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 8'($urandom_range(1, 8));
		else if (roll < 80)
			return 8'($urandom_range(9, 64));
		else if (roll < 90)
			return 8'($urandom_range(65, 255));
		else if (roll < 95)
			return 8'd0;
		return 8'($urandom_range(0, 255));
	endfunction

	// reset settings: idle tick, zero time, tick ignores need_time
	task automatic test_empty_table();
		issue_request(dps_pkg::OP_TICK, 8'd0);
		sender_gap(1'b1);
		issue_request(dps_pkg::OP_ADD, 8'd0);
		issue_request(dps_pkg::OP_TICK, 8'hFF);
	endtask

	// fill every slot, with equal priorities that the next test's ticks use to check the low-slot tie rule, then overflow
	task automatic test_table_full();
		logic [7:0] needs [NSLOTS];
		needs = '{8'd255, 8'd1, 8'd1, 8'd128, 8'd127, 8'd3, 8'd3, 8'd3,
			8'd3, 8'd2, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8};
		for (int i = 0; i < NSLOTS; i++) begin
			issue_request(dps_pkg::OP_ADD, needs[i]);
			sender_gap(1'b1);
		end
		issue_request(dps_pkg::OP_ADD, 8'd5);
	endtask

	// finished processes free their slots for new adds
	task automatic test_slot_reuse();
		issue_request(dps_pkg::OP_TICK, 8'd0);
		issue_request(dps_pkg::OP_TICK, 8'd0);
		issue_request(dps_pkg::OP_ADD, 8'd255);
		sender_gap(1'b1);
		issue_request(dps_pkg::OP_ADD, 8'd64);
		issue_request(dps_pkg::OP_ADD, 8'd1);
	endtask

	task automatic test_random_phases();
		bit gaps_on;
		int add_pct;
		logic o;
		logic [7:0] n;
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: begin
					load_settings(8'd0, 4'd0);
				end
				1: begin
					load_settings(8'd255, 4'd15);
				end
				2: begin
					load_settings(8'd0, 4'd15);
				end
				default: begin
					load_settings(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
				end
			endcase
			add_pct = $urandom_range(25, 60);
			gaps_on = 1'b1;
			for (int k = 0; k < 125; k++) begin
				if (k % 40 == 0)
					gaps_on = ($urandom_range(0, 3) != 0);
				o = ($urandom_range(0, 99) < add_pct) ? dps_pkg::OP_ADD : dps_pkg::OP_TICK;
				n = (o == dps_pkg::OP_ADD) ? random_need() : 8'($urandom_range(0, 255));
				issue_request(o, n);
				sender_gap(gaps_on);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_table_full();
		test_slot_reuse();
		test_random_phases();
		settle();
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#(12 * 500000);
		$display("testbench failed");
		$finish;
	end

endmodule
